FILE: hdl/key_press_event_buffer_assert.svh
// Assertion macros for the key press event buffer.
// Each property is sampled on clk and switched off while rst_n is low.
`ifndef KEY_PRESS_EVENT_BUFFER_ASSERT_SVH
`define KEY_PRESS_EVENT_BUFFER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define KPEB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kpeb assertion failed");
// Next-cycle implication.
`define KPEB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kpeb assertion failed");
`else
`define KPEB_ASSERT_IMP(lbl, ante, cons)
`define KPEB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/kpeb_pkg.sv
`timescale 1ns / 1ps
package kpeb_pkg;

  localparam int CODE_W = 7;
  localparam int BREAK_BIT = 7;

  // action codes
  localparam logic [2:0] ACT_FRAME  = 3'd0;
  localparam logic [2:0] ACT_CODE   = 3'd1;
  localparam logic [2:0] ACT_QUERY  = 3'd2;
  localparam logic [2:0] ACT_FLUSH  = 3'd3;
  localparam logic [2:0] ACT_IGNORE = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] scan_code;
    logic [7:0] ignore_frames;
  } in_t;

  typedef struct packed {
    logic       found;
    logic       dropped_oldest;
    logic [6:0] stored_count;
  } out_t;

  // controls broadcast to every cell of the store
  typedef struct packed {
    logic load;      // write the new code into the cell at the pointer
    logic shift_all; // every cell takes its upper neighbour
    logic scan;      // compare the cell at the pointer with the query
    logic compact;   // cells at and above the pointer take their upper neighbour
  } cell_ctrl_t;

endpackage

FILE: hdl/key_press_event_buffer.sv
`timescale 1ns / 1ps
// Key press event buffer.
// Input channel in_valid / in_stall / in_data carries one command beat:
// frame start, scan code, query, flush or set ignore. Every beat gives
// exactly one result beat on out_valid / out_stall / out_data with the
// found flag, the dropped-oldest flag and the number of stored codes.
// Codes sit in a row of cells, oldest in cell 0. An append or a full-store
// shift is written into the cells as the beat is taken; apart from a walking
// query, the result appears the cycle after the beat. A query walks the row
// one cell per cycle from the oldest entry unless the receiver stalls, up
// to the match or the newest stored code; a hit closes the gap in the
// same cycle by shifting the upper cells down. in_stall is high while a
// query walks; other commands sustain one beat per cycle unless stalled.
// Reset empties the store, clears the ignore count and the discarding
// flag; cell contents are not cleared. When the receiver stalls, the result
// is held in the output register, a walking query pauses, and in_stall
// rises until the result beat is taken.
module key_press_event_buffer #(
  parameter int STORE_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  kpeb_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output kpeb_pkg::out_t  out_data
);

  `include "key_press_event_buffer_assert.svh"

  localparam int PTR_W = $clog2(STORE_DEPTH + 1);

  logic [PTR_W-1:0]            count_r, count_nxt;
  logic [PTR_W-1:0]            k_r, k_nxt;
  logic                        scan_r, scan_nxt;
  logic [7:0]                  q_r, q_nxt;
  logic [7:0]                  ign_r, ign_nxt;
  logic                        discard_r, discard_nxt;
  logic                        out_valid_r, out_valid_nxt;
  kpeb_pkg::out_t              out_r, out_nxt;

  logic                        in_acc;
  logic                        out_free;
  logic                        scan_go;
  logic                        scan_last;
  logic                        hit_any;
  logic                        full;
  logic                        is_append;
  logic                        res_go;
  logic                        res_found;
  logic                        res_drop;
  logic [PTR_W-1:0]            ptr;
  kpeb_pkg::cell_ctrl_t        ctl;
  logic [kpeb_pkg::CODE_W-1:0] cell_code [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]      hit_vec;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = scan_r || !out_free;
  assign scan_go   = scan_r && out_free;
  assign hit_any   = |hit_vec;
  assign scan_last = ((k_r + PTR_W'(1)) == count_r);
  assign full      = (count_r == PTR_W'(STORE_DEPTH));
  assign is_append = in_acc && (in_data.action == kpeb_pkg::ACT_CODE) && !discard_r
                     && !in_data.scan_code[kpeb_pkg::BREAK_BIT];
  assign ptr       = scan_r ? k_r : count_r;

  // drive the row of cells
  always_comb begin
    ctl.load      = is_append && !full;
    ctl.shift_all = is_append && full;
    ctl.scan      = scan_go;
    ctl.compact   = scan_go && hit_any;
  end

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic [kpeb_pkg::CODE_W-1:0] nbr;
    if (i == STORE_DEPTH - 1) begin : g_last
      assign nbr = in_data.scan_code[kpeb_pkg::CODE_W-1:0];
    end else begin : g_mid
      assign nbr = cell_code[i+1];
    end
    kpeb_cell #(
      .IDX   (i),
      .PTR_W (PTR_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ptr       (ptr),
      .q_code    (q_r),
      .next_code (nbr),
      .load_code (in_data.scan_code[kpeb_pkg::CODE_W-1:0]),
      .code_o    (cell_code[i]),
      .hit_o     (hit_vec[i])
    );
  end

  // command decode and query walk
  always_comb begin
    count_nxt   = count_r;
    k_nxt       = k_r;
    scan_nxt    = scan_r;
    q_nxt       = q_r;
    ign_nxt     = ign_r;
    discard_nxt = discard_r;
    res_go      = 1'b0;
    res_found   = 1'b0;
    res_drop    = 1'b0;
    if (scan_go) begin
      if (hit_any) begin
        count_nxt = count_r - PTR_W'(1);
        scan_nxt  = 1'b0;
        res_go    = 1'b1;
        res_found = 1'b1;
      end else if (scan_last) begin
        scan_nxt = 1'b0;
        res_go   = 1'b1;
      end else begin
        k_nxt = k_r + PTR_W'(1);
      end
    end else if (in_acc) begin
      res_go = 1'b1;
      case (in_data.action)
        kpeb_pkg::ACT_FRAME: begin
          if (ign_r != 8'd0) begin
            ign_nxt     = ign_r - 8'd1;
            discard_nxt = 1'b1;
          end else begin
            discard_nxt = 1'b0;
          end
        end
        kpeb_pkg::ACT_CODE: begin
          if (is_append) begin
            if (full) begin
              res_drop = 1'b1;
            end else begin
              count_nxt = count_r + PTR_W'(1);
            end
          end
        end
        kpeb_pkg::ACT_QUERY: begin
          // start a walk unless nothing can match
          if (count_r != '0 && !in_data.scan_code[kpeb_pkg::BREAK_BIT]) begin
            res_go   = 1'b0;
            scan_nxt = 1'b1;
            k_nxt    = '0;
            q_nxt    = in_data.scan_code;
          end
        end
        kpeb_pkg::ACT_FLUSH: begin
          count_nxt   = '0;
          ign_nxt     = 8'd0;
          discard_nxt = 1'b0;
        end
        kpeb_pkg::ACT_IGNORE: begin
          ign_nxt = in_data.ignore_frames;
        end
        default: begin
        end
      endcase
    end
  end

  // result register: load a new beat or hold a stalled one
  always_comb begin
    out_nxt                = out_r;
    out_valid_nxt          = out_valid_r && out_stall;
    if (res_go) begin
      out_valid_nxt          = 1'b1;
      out_nxt.found          = res_found;
      out_nxt.dropped_oldest = res_drop;
      out_nxt.stored_count   = 7'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      k_r         <= '0;
      scan_r      <= 1'b0;
      ign_r       <= 8'd0;
      discard_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      scan_r      <= scan_nxt;
      ign_r       <= ign_nxt;
      discard_r   <= discard_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `KPEB_ASSERT_IMP(a_count_bound, 1'b1, count_r <= PTR_W'(STORE_DEPTH))
  `KPEB_ASSERT_IMP(a_walk_stalls, scan_r, in_stall)
  `KPEB_ASSERT_IMP(a_walk_in_range, scan_r, k_r < count_r)
  `KPEB_ASSERT_IMP(a_single_hit, 1'b1, $onehot0(hit_vec))
  `KPEB_ASSERT_NXT(a_hit_reports, scan_go && hit_any, out_valid_r && out_r.found)

endmodule

FILE: hdl/kpeb_cell.sv
`timescale 1ns / 1ps
module kpeb_cell #(
  parameter int IDX   = 0,
  parameter int PTR_W = 7
) (
  input  logic                       clk,
  input  kpeb_pkg::cell_ctrl_t       ctl,
  input  logic [PTR_W-1:0]           ptr,
  input  logic [7:0]                 q_code,
  input  logic [kpeb_pkg::CODE_W-1:0] next_code,
  input  logic [kpeb_pkg::CODE_W-1:0] load_code,
  output logic [kpeb_pkg::CODE_W-1:0] code_o,
  output logic                       hit_o
);

  logic [kpeb_pkg::CODE_W-1:0] code_r;
  logic                        at_ptr;
  logic                        above_ptr;

  assign at_ptr    = (ptr == PTR_W'(IDX));
  assign above_ptr = (PTR_W'(IDX) >= ptr);

  // compare the held code with the query; a break code never matches
  assign hit_o  = ctl.scan && at_ptr && ({1'b0, code_r} == q_code);
  assign code_o = code_r;

  // load a new code, or take the neighbour's code on a shift
  always_ff @(posedge clk) begin
    if (ctl.load && at_ptr) begin
      code_r <= load_code;
    end else if (ctl.shift_all || (ctl.compact && above_ptr)) begin
      code_r <= next_code;
    end
  end

endmodule

FILE: sim/key_press_event_buffer_tb.sv
`timescale 1ns / 1ps
module key_press_event_buffer_tb;

  localparam int STORE_DEPTH = 64;
  localparam int ITEM_TARGET = 1800;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = STORE_DEPTH + 16;
  localparam int MAX_REPORTS = 10;
  // action codes the block leaves unused
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kpeb_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kpeb_pkg::out_t out_data;

  key_press_event_buffer #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // predicted state of the key store
  logic [kpeb_pkg::CODE_W-1:0] held_codes [STORE_DEPTH];
  int held_count = 0;
  logic [7:0] frames_to_skip = '0;
  bit skipping_frame = 1'b0;

  kpeb_pkg::out_t expected_results[$];

  int burst_left = 0;
  int beats_sent = 0;
  int spare_beats = 0;
  int results_checked = 0;
  int query_hits = 0;
  int oldest_drops = 0;
  int skipped_codes = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  int stall_phase_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // update the predicted store for one command beat and give its result
  task automatic apply_key_event(input kpeb_pkg::in_t beat, output kpeb_pkg::out_t res);
    int hit_at;
    res = '0;
    hit_at = -1;
    case (beat.action)
      kpeb_pkg::ACT_FRAME: begin
        if (frames_to_skip != 0) begin
          frames_to_skip--;
          skipping_frame = 1'b1;
        end else begin
          skipping_frame = 1'b0;
        end
      end
      kpeb_pkg::ACT_CODE: begin
        if (skipping_frame) begin
          skipped_codes++;
        end else if (!beat.scan_code[kpeb_pkg::BREAK_BIT]) begin
          if (held_count >= STORE_DEPTH) begin
            // shift out the oldest code to make room
            for (int i = 0; i < STORE_DEPTH - 1; i++)
              held_codes[i] = held_codes[i + 1];
            held_codes[STORE_DEPTH - 1] = beat.scan_code[kpeb_pkg::CODE_W-1:0];
            res.dropped_oldest = 1'b1;
            oldest_drops++;
          end else begin
            held_codes[held_count] = beat.scan_code[kpeb_pkg::CODE_W-1:0];
            held_count++;
          end
        end
      end
      kpeb_pkg::ACT_QUERY: begin
        for (int i = 0; i < held_count; i++) begin
          if (hit_at < 0 && {1'b0, held_codes[i]} == beat.scan_code) hit_at = i;
        end
        // consume the oldest match and close the gap
        if (hit_at >= 0) begin
          for (int i = hit_at; i < held_count - 1; i++) held_codes[i] = held_codes[i + 1];
          held_count--;
          res.found = 1'b1;
          query_hits++;
        end
      end
      kpeb_pkg::ACT_FLUSH: begin
        held_count = 0;
        frames_to_skip = '0;
        skipping_frame = 1'b0;
      end
      kpeb_pkg::ACT_IGNORE: begin
        frames_to_skip = beat.ignore_frames;
      end
      default: begin
        spare_beats++;
      end
    endcase
    res.stored_count = 7'(held_count);
  endtask

  function automatic kpeb_pkg::in_t make_beat(logic [2:0] act, logic [7:0] code,
                                              logic [7:0] frames);
    kpeb_pkg::in_t beat;
    beat.action = act;
    beat.scan_code = code;
    beat.ignore_frames = frames;
    return beat;
  endfunction

  // a code currently held, so that a query is likely to hit
  function automatic logic [7:0] pick_held_code();
    if (held_count == 0) return {1'b0, 7'($urandom_range(0, 15))};
    return {1'b0, held_codes[$urandom_range(0, held_count - 1)]};
  endfunction

  // drive one beat in bursts with random gaps, then predict its result
  task automatic send_beat(input kpeb_pkg::in_t beat);
    kpeb_pkg::out_t res;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
    apply_key_event(beat, res);
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // receiver stalls: phases of no stall, light stall and heavy stall
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_phase_left = $urandom_range(20, 200);
    end else begin
      stall_phase_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    kpeb_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b dropped=%0b count=%0d",
                        out_data.found, out_data.dropped_oldest, out_data.stored_count));
      end else begin
        want = expected_results.pop_front();
        if (out_data.found !== want.found || out_data.dropped_oldest !== want.dropped_oldest ||
            out_data.stored_count !== want.stored_count)
          report_mismatch($sformatf(
            "found exp %0b got %0b, dropped exp %0b got %0b, count exp %0d got %0d",
            want.found, out_data.found, want.dropped_oldest, out_data.dropped_oldest,
            want.stored_count, out_data.stored_count));
      end
    end
  end

  // codes arrive before any frame start; break codes are dropped
  task automatic test_codes_before_frame();
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'h00, 8'h00));
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'h7F, 8'hFF));
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'h80, 8'h00));
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'hFF, 8'hFF));
  endtask

  // queries: break code, hit, miss, hit that empties the store
  task automatic test_queries();
    send_beat(make_beat(kpeb_pkg::ACT_QUERY, 8'hFF, 8'h00));
    send_beat(make_beat(kpeb_pkg::ACT_QUERY, 8'h7F, 8'hFF));
    send_beat(make_beat(kpeb_pkg::ACT_QUERY, 8'h55, 8'h00));
    send_beat(make_beat(kpeb_pkg::ACT_QUERY, 8'h00, 8'hFF));
  endtask

  // ignore count: current frame unaffected, next frames discarded
  task automatic test_ignore_frames();
    send_beat(make_beat(kpeb_pkg::ACT_IGNORE, 8'($urandom), 8'd2));
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'h11, 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_FRAME, 8'($urandom), 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'h22, 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_FRAME, 8'($urandom), 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_FRAME, 8'($urandom), 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'h33, 8'($urandom)));
  endtask

  // flush ends a discarding frame and clears a full ignore count
  task automatic test_flush();
    send_beat(make_beat(kpeb_pkg::ACT_IGNORE, 8'($urandom), 8'hFF));
    send_beat(make_beat(kpeb_pkg::ACT_FRAME, 8'($urandom), 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'h44, 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_FLUSH, 8'($urandom), 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_CODE, 8'h45, 8'($urandom)));
    send_beat(make_beat(kpeb_pkg::ACT_IGNORE, 8'($urandom), 8'h00));
    send_beat(make_beat(kpeb_pkg::ACT_FRAME, 8'($urandom), 8'($urandom)));
  endtask

  task automatic test_spare_actions();
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      send_beat(make_beat(3'(a), 8'($urandom), 8'($urandom)));
  endtask

  // fill past capacity so the oldest codes get shifted out
  task automatic test_store_overflow();
    repeat (3) begin
      send_beat(make_beat(kpeb_pkg::ACT_FLUSH, 8'($urandom), 8'($urandom)));
      send_beat(make_beat(kpeb_pkg::ACT_FRAME, 8'($urandom), 8'($urandom)));
      repeat (STORE_DEPTH + $urandom_range(1, 16))
        send_beat(make_beat(kpeb_pkg::ACT_CODE, {1'b0, 7'($urandom)}, 8'($urandom)));
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 3) == 0)
          send_beat(make_beat(kpeb_pkg::ACT_QUERY, 8'($urandom), 8'($urandom)));
        else
          send_beat(make_beat(kpeb_pkg::ACT_QUERY, pick_held_code(), 8'($urandom)));
      end
    end
  endtask

  // mostly frames of keystrokes and queries, some noise beats
  task automatic test_random_mix();
    logic [2:0] act;
    logic [7:0] frames;
    int pick;
    while (beats_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        send_beat(make_beat(kpeb_pkg::ACT_FRAME, 8'($urandom), 8'($urandom)));
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 9);
          if (pick < 6)
            send_beat(make_beat(kpeb_pkg::ACT_CODE,
                                ($urandom_range(0, 3) == 0) ? {1'b0, 7'($urandom)} :
                                {1'b0, 7'($urandom_range(0, 15))}, 8'($urandom)));
          else if (pick < 8)
            send_beat(make_beat(kpeb_pkg::ACT_CODE, {1'b1, 7'($urandom)}, 8'($urandom)));
          else
            send_beat(make_beat(kpeb_pkg::ACT_QUERY, pick_held_code(), 8'($urandom)));
        end
        repeat ($urandom_range(0, 3))
          send_beat(make_beat(kpeb_pkg::ACT_QUERY, pick_held_code(), 8'($urandom)));
      end else begin
        act = 3'($urandom_range(0, 7));
        frames = 8'($urandom);
        if (act == kpeb_pkg::ACT_IGNORE && $urandom_range(0, 3) != 0)
          frames = 8'($urandom_range(0, 3));
        send_beat(make_beat(act, 8'($urandom), frames));
      end
    end
  endtask

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** key_press_event_buffer: FAILED **");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_codes_before_frame();
    test_queries();
    test_ignore_frames();
    test_flush();
    test_spare_actions();
    test_store_overflow();
    test_random_mix();
    in_valid <= 1'b0;
    // drain outstanding results, then watch for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d command beats (%0d on unused actions); checked %0d results.",
             beats_sent, spare_beats, results_checked);
    $display("Saw %0d query hits, %0d oldest-code drops, %0d codes in skipped frames;",
             query_hits, oldest_drops, skipped_codes);
    $display("%0d mismatches.", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** key_press_event_buffer: PASSED **");
    end else begin
      $display("** key_press_event_buffer: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/kpeb_pkg.sv
hdl/kpeb_cell.sv
hdl/key_press_event_buffer.sv
sim/key_press_event_buffer_tb.sv
